// ===== src/integer_task_function_unit_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer task function unit
// Shared property wrappers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TASK_FUNCTION_UNIT_CORE_MACROS_SVH
`define INTEGER_TASK_FUNCTION_UNIT_CORE_MACROS_SVH

// same-cycle implication
`define ITFU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("itfu: same-cycle check failed");

// next-cycle implication
`define ITFU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("itfu: next-cycle check failed");

`endif

// ===== src/itfu_pkg.sv =====
// ----------------------------------------------------------------------------
// itfu_pkg
// Types, codes and constants shared by the integer task function unit.
// ----------------------------------------------------------------------------
package itfu_pkg;

	localparam int ARG_WIDTH_DEF = 32;
	localparam int ARG_PORT_W    = 32;
	localparam int MODE_W        = 3;
	localparam int TAG_W         = 16;
	localparam int VAL_W         = 64;
	localparam int ERR_W         = 2;
	localparam int CNT_W         = 7;

	localparam int FACT_MAX  = 20;
	localparam int FIB_MAX   = 92;
	localparam int DEC_BASE  = 10;
	localparam int WHEEL     = 6;
	localparam int WHEEL_GAP = 2;
	localparam int FIRST_DIV = 5;
	localparam int SMALL_DIV = 3;

	// reciprocals for exact unsigned division of a 32-bit operand by 10 and 3
	localparam logic [ARG_PORT_W-1:0] RECIP10    = 32'hCCCC_CCCD;
	localparam int                    RECIP10_SH = 35;
	localparam logic [ARG_PORT_W-1:0] RECIP3     = 32'hAAAA_AAAB;
	localparam int                    RECIP3_SH  = 33;

	localparam logic [MODE_W-1:0] MODE_FACT  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FIB   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DSUM  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PRIME = 3'd3;
	localparam logic [MODE_W-1:0] MODE_GCD   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_REV   = 3'd5;

	localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_W-1:0] ERR_NEG  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_BIG  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_FACT, S_FIB, S_DIG, S_DIGW, S_P3,
		S_PCHK, S_PW1, S_PW2, S_GCD, S_GW, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_INIT_FACT, OP_INIT_FIB, OP_INIT_DIG, OP_INIT_GCD,
		OP_STEP_FACT, OP_STEP_FIB, OP_DIV, OP_UPD_DIG, OP_INIT_PRIME,
		OP_NEXT_PRIME, OP_UPD_GCD, OP_RES, OP_OUT, OP_CDIV
	} op_t;

	typedef enum logic [2:0] {
		RV_ZERO, RV_ONE, RV_ACC, RV_DIG, RV_GCD
	} vsel_t;

	typedef enum logic [2:0] {
		DS_DIG, DS_P3, DS_PI, DS_PI2, DS_GCD
	} dsel_t;

	typedef struct packed {
		op_t              op;
		vsel_t            vsel;
		dsel_t            dsel;
		logic [ERR_W-1:0] err;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic neg;
		logic fact_big;
		logic fib_big;
		logic cnt_gt;
		logic m_zero;
		logic le1;
		logic le3;
		logic even;
		logic sq_gt;
		logic y_zero;
		logic div_done;
		logic rem_zero;
		logic rem3_zero;
		logic out_free;
	} stat_t;

endpackage

// ===== src/itfu_if.sv =====
// ----------------------------------------------------------------------------
// itfu_req_if / itfu_rsp_if
// Valid/ready channels for task items and result items.
// ----------------------------------------------------------------------------
interface itfu_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [31:0] arg_a;
	logic [31:0] arg_b;
	logic [15:0] tag;

	modport source (output valid, mode, arg_a, arg_b, tag, input ready);
	modport sink   (input valid, mode, arg_a, arg_b, tag, output ready);
endinterface

interface itfu_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] tag_out;
	logic [63:0] value;
	logic        ok;
	logic [1:0]  error_code;

	modport source (output valid, tag_out, value, ok, error_code, input ready);
	modport sink   (input valid, tag_out, value, ok, error_code, output ready);
endinterface

// ===== src/integer_task_function_unit_core.sv =====
// ----------------------------------------------------------------------------
// integer_task_function_unit_core
// Iterative integer unit: factorial, Fibonacci, digit sum, prime test, GCD
// and digit reversal, one task at a time, one result item per task.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  req     | in  | valid / ready   | mode, arg_a, arg_b, tag
//  rsp     | out | valid / ready   | tag_out, value, ok, error_code
//
//  Errors and trivial cases finish straight from dispatch; factorial and
//  Fibonacci take one step per index up to n; digit ops take one reciprocal
//  division and one update per decimal digit; GCD runs the divider once per
//  Euclid step; the prime test checks for a factor 3, then divides by i and
//  i + 2 for each i = 5 + 6k, up to sqrt(n) / 6 pairs. Digits and the test
//  by 3 use a reciprocal product; the rest use the one-bit-per-cycle divider.
//  Reset clears the controller, the divider count and the result valid flag.
//  A stalled result sits in the output register; the next item is taken
//  meanwhile, and its own result waits in S_DONE until that register frees.
// ----------------------------------------------------------------------------
`include "integer_task_function_unit_core_macros.svh"

module integer_task_function_unit_core #(
	parameter int ARG_WIDTH = itfu_pkg::ARG_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	itfu_req_if.sink   req,
	itfu_rsp_if.source rsp
);
	import itfu_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  ready;

	// controller: owns the input handshake and the task sequence
	itfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	assign req.ready = ready;

	// datapath: operands, loop registers, divider and output register
	itfu_dp #(.ARG_WIDTH(ARG_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.mode      (req.mode),
		.arg_a     (req.arg_a),
		.arg_b     (req.arg_b),
		.tag       (req.tag),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_tag   (rsp.tag_out),
		.rsp_value (rsp.value),
		.rsp_ok    (rsp.ok),
		.rsp_err   (rsp.error_code)
	);

	// an error result carries a code and a zero value
	`ITFU_ASSERT_IMP(a_err_zero, clk, arst_n, rsp.valid && !rsp.ok, rsp.value == '0 && rsp.error_code != ERR_NONE)
	// a good result carries no code
	`ITFU_ASSERT_IMP(a_ok_code, clk, arst_n, rsp.valid && rsp.ok, rsp.error_code == ERR_NONE)
	// after taking an item, hold off the next one
	`ITFU_ASSERT_NXT(a_busy, clk, arst_n, req.valid && req.ready, !req.ready)
endmodule

// ===== src/itfu_div.sv =====
// ----------------------------------------------------------------------------
// itfu_div
// Restoring divider, one quotient bit per cycle; pulses done when finished.
// ----------------------------------------------------------------------------
module itfu_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  r_q, q_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W:0]    trial, diff;
	logic          ge;

	always_comb begin
		trial = {r_q, q_q[W-1]};
		diff  = trial - {1'b0, d_q};
		ge    = ~diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1)) && !start;
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			q_q <= dividend;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			r_q <= ge ? diff[W-1:0] : trial[W-1:0];
			q_q <= {q_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign rem  = r_q;
endmodule

// ===== src/itfu_dp.sv =====
// ----------------------------------------------------------------------------
// itfu_dp
// Datapath: operand registers, accumulators, shared divider, result register.
// ----------------------------------------------------------------------------
module itfu_dp #(
	parameter int ARG_WIDTH = itfu_pkg::ARG_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  itfu_pkg::cmd_t                 cmd,
	output itfu_pkg::stat_t                stat,
	input  logic [itfu_pkg::MODE_W-1:0]    mode,
	input  logic [itfu_pkg::ARG_PORT_W-1:0] arg_a,
	input  logic [itfu_pkg::ARG_PORT_W-1:0] arg_b,
	input  logic [itfu_pkg::TAG_W-1:0]     tag,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [itfu_pkg::TAG_W-1:0]     rsp_tag,
	output logic [itfu_pkg::VAL_W-1:0]     rsp_value,
	output logic                           rsp_ok,
	output logic [itfu_pkg::ERR_W-1:0]     rsp_err
);
	import itfu_pkg::*;

	localparam int W  = ARG_WIDTH;
	localparam int PW = 2 * ARG_PORT_W;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
		mag_of = x[W-1] ? (~x + W'(1)) : x;
	endfunction

	logic [MODE_W-1:0] mode_q;
	logic [TAG_W-1:0]  tag_q;
	logic              neg_q;
	logic [W-1:0]      mag_a_q, mag_b_q, m_q, i_q, x_q, y_q;
	logic [2*W-1:0]    sq_q;
	logic [VAL_W-1:0]  acc_q, p_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [ERR_W-1:0]  res_err_q;

	logic [TAG_W-1:0]  out_tag_q;
	logic [VAL_W-1:0]  out_val_q;
	logic [ERR_W-1:0]  out_err_q;
	logic              out_valid_q;

	logic              div_start, div_done;
	logic [W-1:0]      div_n, div_d, div_r;
	logic [VAL_W+CNT_W-1:0] prod;
	logic [VAL_W-1:0]  res_val_d;

	// constant division by 10 or 3 through a reciprocal product
	logic [ARG_PORT_W-1:0] cdiv_n, cdiv_k;
	logic [PW-1:0]         cdiv_prod;
	logic [W-1:0]          cq_d, cq_q, rem10, rem3;

	itfu_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.rem      (div_r)
	);

	assign div_start = (cmd.op == OP_DIV);

	always_comb begin
		case (cmd.dsel)
			DS_PI: begin
				div_n = mag_a_q;
				div_d = i_q;
			end
			DS_PI2: begin
				div_n = mag_a_q;
				div_d = i_q + W'(WHEEL_GAP);
			end
			DS_GCD: begin
				div_n = x_q;
				div_d = y_q;
			end
			default: begin
				div_n = x_q;
				div_d = y_q;
			end
		endcase
	end

	always_comb begin
		case (cmd.dsel)
			DS_P3: begin
				cdiv_n = ARG_PORT_W'(mag_a_q);
				cdiv_k = RECIP3;
			end
			default: begin
				cdiv_n = ARG_PORT_W'(m_q);
				cdiv_k = RECIP10;
			end
		endcase
		cdiv_prod = PW'(cdiv_n) * PW'(cdiv_k);
		if (cmd.dsel == DS_P3) begin
			cq_d = W'(cdiv_prod[PW-1:RECIP3_SH]);
		end else begin
			cq_d = W'(cdiv_prod[PW-1:RECIP10_SH]);
		end
	end

	// remainders from the held quotient: m - 10q and a - 3q
	assign rem10 = m_q - ((cq_q << 3) + (cq_q << 1));
	assign rem3  = mag_a_q - ((cq_q << 1) + cq_q);

	assign prod = (VAL_W+CNT_W)'(acc_q) * (VAL_W+CNT_W)'(cnt_q);

	always_comb begin
		case (cmd.vsel)
			RV_ZERO: res_val_d = '0;
			RV_ONE:  res_val_d = VAL_W'(1);
			RV_ACC:  res_val_d = acc_q;
			RV_DIG:  res_val_d = (mode_q == MODE_REV && neg_q) ? (~acc_q + VAL_W'(1)) : acc_q;
			RV_GCD:  res_val_d = VAL_W'(x_q);
			default: res_val_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mode_q  <= mode;
				tag_q   <= tag;
				neg_q   <= arg_a[W-1];
				mag_a_q <= mag_of(arg_a[W-1:0]);
				mag_b_q <= mag_of(arg_b[W-1:0]);
			end
			OP_INIT_FACT: begin
				acc_q <= VAL_W'(1);
				cnt_q <= CNT_W'(2);
			end
			OP_INIT_FIB: begin
				p_q   <= '0;
				acc_q <= (mag_a_q != '0) ? VAL_W'(1) : '0;
				cnt_q <= CNT_W'(2);
			end
			OP_INIT_DIG: begin
				acc_q <= '0;
				m_q   <= mag_a_q;
			end
			OP_INIT_GCD: begin
				x_q <= mag_a_q;
				y_q <= mag_b_q;
			end
			OP_STEP_FACT: begin
				acc_q <= prod[VAL_W-1:0];
				cnt_q <= cnt_q + CNT_W'(1);
			end
			OP_STEP_FIB: begin
				p_q   <= acc_q;
				acc_q <= p_q + acc_q;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			OP_CDIV: begin
				cq_q <= cq_d;
			end
			OP_UPD_DIG: begin
				m_q <= cq_q;
				if (mode_q == MODE_REV) begin
					acc_q <= (acc_q << 3) + (acc_q << 1) + VAL_W'(rem10);
				end else begin
					acc_q <= acc_q + VAL_W'(rem10);
				end
			end
			OP_INIT_PRIME: begin
				i_q  <= W'(FIRST_DIV);
				sq_q <= (2*W)'(FIRST_DIV * FIRST_DIV);
			end
			OP_NEXT_PRIME: begin
				i_q  <= i_q + W'(WHEEL);
				// (i+6)^2 = i^2 + 12i + 36
				sq_q <= sq_q + ((2*W)'(i_q) << 3) + ((2*W)'(i_q) << 2)
					+ (2*W)'(WHEEL * WHEEL);
			end
			OP_UPD_GCD: begin
				x_q <= y_q;
				y_q <= div_r;
			end
			OP_RES: begin
				res_val_q <= res_val_d;
				res_err_q <= cmd.err;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_tag_q <= tag_q;
			out_val_q <= res_val_q;
			out_err_q <= res_err_q;
		end
	end

	always_comb begin
		stat.mode      = mode_q;
		stat.neg       = neg_q;
		stat.fact_big  = mag_a_q > W'(FACT_MAX);
		stat.fib_big   = mag_a_q > W'(FIB_MAX);
		stat.cnt_gt    = cnt_q > mag_a_q[CNT_W-1:0];
		stat.m_zero    = (m_q == '0);
		stat.le1       = neg_q || (mag_a_q <= W'(1));
		stat.le3       = mag_a_q <= W'(SMALL_DIV);
		stat.even      = ~mag_a_q[0];
		stat.sq_gt     = sq_q > (2*W)'(mag_a_q);
		stat.y_zero    = (y_q == '0);
		stat.div_done  = div_done;
		stat.rem_zero  = (div_r == '0);
		stat.rem3_zero = (rem3 == '0);
		stat.out_free  = !out_valid_q || rsp_ready;
	end

	assign rsp_valid = out_valid_q;
	assign rsp_tag   = out_tag_q;
	assign rsp_value = out_val_q;
	assign rsp_ok    = (out_err_q == ERR_NONE);
	assign rsp_err   = out_err_q;
endmodule

// ===== src/itfu_ctrl.sv =====
// ----------------------------------------------------------------------------
// itfu_ctrl
// Controller: sequences each task through the datapath by commands.
// ----------------------------------------------------------------------------
module itfu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  itfu_pkg::stat_t stat,
	output itfu_pkg::cmd_t  cmd
);
	import itfu_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DISP;
			end
			S_DISP: begin
				case (stat.mode)
					MODE_FACT:  state_d = (stat.neg || stat.fact_big) ? S_DONE : S_FACT;
					MODE_FIB:   state_d = (stat.neg || stat.fib_big) ? S_DONE : S_FIB;
					MODE_DSUM:  state_d = S_DIG;
					MODE_REV:   state_d = S_DIG;
					MODE_PRIME: state_d = (stat.le1 || stat.le3 || stat.even) ? S_DONE : S_P3;
					MODE_GCD:   state_d = S_GCD;
					default:    state_d = S_DONE;
				endcase
			end
			S_FACT: begin
				if (stat.cnt_gt) state_d = S_DONE;
			end
			S_FIB: begin
				if (stat.cnt_gt) state_d = S_DONE;
			end
			S_DIG: begin
				state_d = stat.m_zero ? S_DONE : S_DIGW;
			end
			S_DIGW: begin
				state_d = S_DIG;
			end
			S_P3: begin
				state_d = stat.rem3_zero ? S_DONE : S_PCHK;
			end
			S_PCHK: begin
				state_d = stat.sq_gt ? S_DONE : S_PW1;
			end
			S_PW1: begin
				if (stat.div_done) state_d = stat.rem_zero ? S_DONE : S_PW2;
			end
			S_PW2: begin
				if (stat.div_done) state_d = stat.rem_zero ? S_DONE : S_PCHK;
			end
			S_GCD: begin
				state_d = stat.y_zero ? S_DONE : S_GW;
			end
			S_GW: begin
				if (stat.div_done) state_d = S_GCD;
			end
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		req_ready = 1'b0;
		cmd.op    = OP_NONE;
		cmd.vsel  = RV_ZERO;
		cmd.dsel  = DS_DIG;
		cmd.err   = ERR_NONE;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) cmd.op = OP_LOAD;
			end
			S_DISP: begin
				case (stat.mode)
					MODE_FACT: begin
						if (stat.neg) begin
							cmd.op  = OP_RES;
							cmd.err = ERR_NEG;
						end else if (stat.fact_big) begin
							cmd.op  = OP_RES;
							cmd.err = ERR_BIG;
						end else begin
							cmd.op = OP_INIT_FACT;
						end
					end
					MODE_FIB: begin
						if (stat.neg) begin
							cmd.op  = OP_RES;
							cmd.err = ERR_NEG;
						end else if (stat.fib_big) begin
							cmd.op  = OP_RES;
							cmd.err = ERR_BIG;
						end else begin
							cmd.op = OP_INIT_FIB;
						end
					end
					MODE_DSUM, MODE_REV: cmd.op = OP_INIT_DIG;
					MODE_PRIME: begin
						if (stat.le1 || stat.le3 || stat.even) begin
							cmd.op   = OP_RES;
							// 2 and 3 are prime; 1, 0, negatives and evens are not
							cmd.vsel = (!stat.le1 && stat.le3) ? RV_ONE : RV_ZERO;
						end else begin
							cmd.op   = OP_CDIV;
							cmd.dsel = DS_P3;
						end
					end
					MODE_GCD: cmd.op = OP_INIT_GCD;
					default:  cmd.op = OP_RES;
				endcase
			end
			S_FACT: begin
				if (stat.cnt_gt) begin
					cmd.op   = OP_RES;
					cmd.vsel = RV_ACC;
				end else begin
					cmd.op = OP_STEP_FACT;
				end
			end
			S_FIB: begin
				if (stat.cnt_gt) begin
					cmd.op   = OP_RES;
					cmd.vsel = RV_ACC;
				end else begin
					cmd.op = OP_STEP_FIB;
				end
			end
			S_DIG: begin
				if (stat.m_zero) begin
					cmd.op   = OP_RES;
					cmd.vsel = RV_DIG;
				end else begin
					cmd.op   = OP_CDIV;
					cmd.dsel = DS_DIG;
				end
			end
			S_DIGW: begin
				cmd.op = OP_UPD_DIG;
			end
			S_P3: begin
				cmd.op = stat.rem3_zero ? OP_RES : OP_INIT_PRIME;
			end
			S_PCHK: begin
				if (stat.sq_gt) begin
					cmd.op   = OP_RES;
					cmd.vsel = RV_ONE;
				end else begin
					cmd.op   = OP_DIV;
					cmd.dsel = DS_PI;
				end
			end
			S_PW1: begin
				if (stat.div_done) begin
					cmd.op   = stat.rem_zero ? OP_RES : OP_DIV;
					cmd.dsel = DS_PI2;
				end
			end
			S_PW2: begin
				if (stat.div_done) cmd.op = stat.rem_zero ? OP_RES : OP_NEXT_PRIME;
			end
			S_GCD: begin
				if (stat.y_zero) begin
					cmd.op   = OP_RES;
					cmd.vsel = RV_GCD;
				end else begin
					cmd.op   = OP_DIV;
					cmd.dsel = DS_GCD;
				end
			end
			S_GW: begin
				if (stat.div_done) cmd.op = OP_UPD_GCD;
			end
			S_DONE: begin
				if (stat.out_free) cmd.op = OP_OUT;
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== tb/integer_task_function_unit_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_task_function_unit_core_tb
// Self-checking bench for the iterative integer unit. Tasks from a pending
// queue go to the request channel. An in-bench predictor computes each
// accepted task's result, and every result item is checked field by field,
// in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module integer_task_function_unit_core_tb;
	import itfu_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int QUIET_LIMIT = 300000;   // slowest prime test plus stalls, with margin
	localparam int HOLD_CYCLES = 400;      // long receiver hold-off for the backlog phase
	localparam int TAIL_CYCLES = 60;

	// modes with no operation
	localparam logic [MODE_W-1:0] MODE_NOP_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_NOP_HI = 3'd7;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [31:0]       arg_a;
		logic [31:0]       arg_b;
		logic [TAG_W-1:0]  tag;
	} task_item_t;

	typedef struct {
		logic [TAG_W-1:0] tag;
		logic [VAL_W-1:0] value;
		logic             ok;
		logic [ERR_W-1:0] err;
	} result_item_t;

	logic clk;
	logic arst_n;

	itfu_req_if req ();
	itfu_rsp_if rsp ();

	integer_task_function_unit_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	task_item_t   pending_tasks[$];
	result_item_t expected_results[$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_kick;
	int hold_seen;
	int hold_left;
	int quiet_cycles;
	int mismatches;
	int tasks_sent;
	int results_checked;
	int mode_count[8];

	// Free-running clock.
	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Compute one task's result the way the unit must.
	function automatic result_item_t compute_result(task_item_t t);
		result_item_t r;
		longint signed   a;
		longint signed   b;
		longint unsigned m;
		longint unsigned acc;
		longint unsigned i;
		longint unsigned p;
		longint unsigned q;
		longint unsigned c;
		longint unsigned x;
		longint unsigned y;
		bit              prime_flag;
		a = $signed(t.arg_a);
		b = $signed(t.arg_b);
		r.tag = t.tag;
		r.value = '0;
		r.ok = 1'b1;
		r.err = ERR_NONE;
		case (t.mode)
			MODE_FACT: begin
				if (a < 0) begin
					r.ok = 1'b0; r.err = ERR_NEG;
				end else if (a > FACT_MAX) begin
					r.ok = 1'b0; r.err = ERR_BIG;
				end else begin
					acc = 1;
					for (i = 2; i <= a; i++) acc = acc * i;
					r.value = acc;
				end
			end
			MODE_FIB: begin
				if (a < 0) begin
					r.ok = 1'b0; r.err = ERR_NEG;
				end else if (a > FIB_MAX) begin
					r.ok = 1'b0; r.err = ERR_BIG;
				end else if (a != 0) begin
					p = 0; q = 1;
					for (i = 2; i <= a; i++) begin
						c = p + q; p = q; q = c;
					end
					r.value = q;
				end
			end
			MODE_DSUM: begin
				m = (a < 0) ? -a : a;
				acc = 0;
				while (m > 0) begin
					acc += m % DEC_BASE; m /= DEC_BASE;
				end
				r.value = acc;
			end
			MODE_PRIME: begin
				if (a <= 1) prime_flag = 0;
				else if (a <= SMALL_DIV) prime_flag = 1;
				else begin
					m = a;
					prime_flag = (m % 2 != 0) && (m % SMALL_DIV != 0);
					for (i = FIRST_DIV; prime_flag && i * i <= m; i += WHEEL)
						if (m % i == 0 || m % (i + WHEEL_GAP) == 0) prime_flag = 0;
				end
				r.value = prime_flag;
			end
			MODE_GCD: begin
				x = (a < 0) ? -a : a;
				y = (b < 0) ? -b : b;
				while (y != 0) begin
					c = y; y = x % y; x = c;
				end
				r.value = x;
			end
			MODE_REV: begin
				m = (a < 0) ? -a : a;
				acc = 0;
				while (m > 0) begin
					acc = acc * DEC_BASE + m % DEC_BASE; m /= DEC_BASE;
				end
				r.value = (a < 0) ? -acc : acc;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Random task: full-range operands for the cheap operations, bounded
	// magnitudes for the prime test so trial division stays short.
	function automatic task_item_t random_task();
		task_item_t t;
		int         pick;
		t.tag = TAG_W'($urandom);
		t.arg_b = ($urandom_range(3) == 0) ? $urandom_range(1000) : $urandom;
		pick = $urandom_range(99);
		t.mode = (pick < 4) ? MODE_W'($urandom_range(MODE_NOP_HI, MODE_NOP_LO))
		                    : MODE_W'($urandom_range(MODE_REV, MODE_FACT));
		case (t.mode)
			MODE_FACT: t.arg_a = ($urandom_range(4) == 0) ? $urandom : $urandom_range(25);
			MODE_FIB:  t.arg_a = ($urandom_range(4) == 0) ? $urandom : $urandom_range(96);
			MODE_PRIME: begin
				case ($urandom_range(3))
					0: t.arg_a = $urandom | 32'h8000_0000;   // negative: never prime
					1: t.arg_a = $urandom_range(200);
					default: t.arg_a = $urandom_range(1 << 20);
				endcase
			end
			MODE_GCD: t.arg_a = ($urandom_range(3) == 0) ? t.arg_b * $urandom_range(9, 1)
			                                            : $urandom;
			default: t.arg_a = ($urandom_range(3) == 0) ? $urandom_range(999) : $urandom;
		endcase
		return t;
	endfunction

	function automatic task_item_t make_task(logic [MODE_W-1:0] mode, logic [31:0] a,
	                                         logic [31:0] b);
		task_item_t t;
		t.mode = mode; t.arg_a = a; t.arg_b = b; t.tag = TAG_W'($urandom);
		return t;
	endfunction

	// Append one task to the pending queue.
	task automatic add_pending(task_item_t t);
		pending_tasks.insert(pending_tasks.size(), t);
	endtask

	// Driver: advance to the next pending task once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.mode  <= '0;
			req.arg_a <= '0;
			req.arg_b <= '0;
			req.tag   <= '0;
		end else if (!req.valid || req.ready) begin
			if (pending_tasks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req.valid <= 1'b1;
				req.mode  <= pending_tasks[0].mode;
				req.arg_a <= pending_tasks[0].arg_a;
				req.arg_b <= pending_tasks[0].arg_b;
				req.tag   <= pending_tasks[0].tag;
				void'(pending_tasks.pop_front());
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_kick) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on task acceptance, check on result acceptance.
	always @(posedge clk) begin
		result_item_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				expected_results.insert(expected_results.size(),
				                        compute_result('{req.mode, req.arg_a, req.arg_b,
				                                         req.tag}));
				mode_count[req.mode]++;
				tasks_sent++;
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with tag %0h arrived with nothing expected",
					       rsp.tag_out);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (rsp.tag_out !== want.tag) begin
						$error("tag_out: expected %0h, got %0h", want.tag, rsp.tag_out);
						mismatches++;
					end
					if (rsp.value !== want.value) begin
						$error("value: expected %0d, got %0d", $signed(want.value),
						       $signed(rsp.value));
						mismatches++;
					end
					if (rsp.ok !== want.ok) begin
						$error("ok: expected %0b, got %0b", want.ok, rsp.ok);
						mismatches++;
					end
					if (rsp.error_code !== want.err) begin
						$error("error_code: expected %0d, got %0d", want.err, rsp.error_code);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: drop the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: %0d tasks pending, %0d results outstanding",
			         pending_tasks.size(), expected_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Hold until every queued task is taken and every result has come back.
	task automatic drain();
		while (pending_tasks.size() > 0 || req.valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	task automatic run_random(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) add_pending(random_task());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		send_idle_pct = 0; recv_stall_pct = 0;
		hold_kick = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: bounds of each operation and the named corner cases.
		add_pending(make_task(MODE_FACT, 32'd0, 32'd0));
		add_pending(make_task(MODE_FACT, 32'd20, 32'hFFFF_FFFF));
		add_pending(make_task(MODE_FACT, 32'd21, 32'd0));
		add_pending(make_task(MODE_FACT, 32'hFFFF_FFFF, 32'd0));
		add_pending(make_task(MODE_FIB, 32'd0, 32'd0));
		add_pending(make_task(MODE_FIB, 32'd1, 32'd0));
		add_pending(make_task(MODE_FIB, 32'd92, 32'd0));
		add_pending(make_task(MODE_FIB, 32'd93, 32'd0));
		add_pending(make_task(MODE_FIB, 32'h8000_0000, 32'd0));
		add_pending(make_task(MODE_DSUM, 32'h7FFF_FFFF, 32'd0));
		add_pending(make_task(MODE_DSUM, 32'h8000_0000, 32'd0));
		add_pending(make_task(MODE_DSUM, 32'd0, 32'd0));
		add_pending(make_task(MODE_PRIME, 32'd1, 32'd0));
		add_pending(make_task(MODE_PRIME, 32'd2, 32'd0));
		add_pending(make_task(MODE_PRIME, 32'd25, 32'd0));
		add_pending(make_task(MODE_PRIME, 32'd65521, 32'd0));
		add_pending(make_task(MODE_PRIME, 32'h8000_0000, 32'd0));
		add_pending(make_task(MODE_GCD, 32'd0, 32'd0));
		add_pending(make_task(MODE_GCD, 32'h8000_0000, 32'h8000_0000));
		add_pending(make_task(MODE_GCD, 32'hFFFF_FFF4, 32'd18));
		add_pending(make_task(MODE_REV, 32'h8000_0000, 32'd0));
		add_pending(make_task(MODE_REV, 32'h7FFF_FFFF, 32'd0));
		add_pending(make_task(MODE_REV, 32'hFFFF_FF85, 32'd0));
		add_pending(make_task(MODE_NOP_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		add_pending(make_task(MODE_NOP_HI, 32'd5, 32'd5));
		drain();

		// Random phases with different idling mixes; the sender pauses between
		// phases until every result is back.
		run_random(100, 0, 0);
		run_random(100, 59, 0);
		run_random(100, 0, 59);
		run_random(100, 30, 30);

		// Backlog: hold the receiver off while cheap tasks keep coming, so the
		// output register and the controller fill and the input stalls.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_kick++;
		repeat (30) add_pending(make_task(MODE_W'($urandom_range(MODE_FIB, MODE_FACT)),
		                                  32'h8000_0000 | $urandom, $urandom));
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d tasks, %0d results checked", tasks_sent, results_checked);
		$display("Per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
		         mode_count[0], mode_count[1], mode_count[2], mode_count[3],
		         mode_count[4], mode_count[5], mode_count[6], mode_count[7]);
		$display("Idling mixes: none, sender, receiver, both, plus a long receiver hold-off");
		if (mismatches == 0 && expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
